/* src/terminal_line_editor_echo_top_macros.svh */
// Assertion helpers for the line editor.
`ifndef TERMINAL_LINE_EDITOR_ECHO_TOP_MACROS_SVH
`define TERMINAL_LINE_EDITOR_ECHO_TOP_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define TLE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/tle_pkg.sv */
package tle_pkg;

   localparam int BYTE_W = 8;
   localparam int STEP_W = 6;
   localparam int LEN_W  = 6;
   localparam int KIND_W = 2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

   // character codes
   localparam logic [BYTE_W-1:0] CH_BS     = 8'd8;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'd10;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
   localparam logic [BYTE_W-1:0] CH_SP     = 8'd32;
   localparam logic [BYTE_W-1:0] CH_DEL    = 8'd127;
   localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
   localparam logic [BYTE_W-1:0] CTRL_OFS  = 8'd64;

   typedef enum logic [1:0] {
      CLS_CTRL,
      CLS_HIGH,
      CLS_PLAIN
   } byte_class_type;

   typedef enum logic [1:0] {
      MODE_ECHO,
      MODE_ERASE,
      MODE_LINE
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ECHO,
      ST_ERASE,
      ST_LINE
   } state_type;

   typedef struct packed {
      logic     load;
      logic     store;
      logic     pop;
      logic     emit;
      logic     clear;
      logic     step_clr;
      mode_type mode;
   } cmd_type;

   typedef struct packed {
      logic is_bs;
      logic is_cr;
      logic empty;
      logic full;
      logic final_step;
      logic out_free;
   } stat_type;

   function automatic byte_class_type byte_class(input logic [BYTE_W-1:0] b);
      byte_class_type c;
      if (b < CH_SP) begin
         c = CLS_CTRL;
      end else if (b > CH_DEL) begin
         c = CLS_HIGH;
      end else begin
         c = CLS_PLAIN;
      end
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
      logic [BYTE_W-1:0] d;
      if (v < 4'd10) begin
         d = 8'h30 + {4'h0, v};
      end else begin
         d = 8'h37 + {4'h0, v};
      end
      return d;
   endfunction

endpackage

/* src/terminal_line_editor_echo_top.sv */
// Terminal line editor with echo.
// req_*: one received byte per beat. rsp_*: result beats - echo bytes
// (tuser 0), bytes of a completed line (tuser 1) and a line-end beat
// (tuser 2) whose tdata[13:8] holds the line length. tlast marks the final
// result beat caused by one received byte.
// Timing: a byte is taken in one cycle and decoded in the next; its first
// result enters the output register once that register is free. Results
// then follow one per cycle unless rsp_tready stalls them (a carriage
// return on a full 32-byte line gives 35 results). A single step counter
// walks the results of each byte; no new byte is taken before the last
// result of the current one has been emitted.
// req_tready is high only while the sequencer is idle, including while the
// last result of the previous byte still waits in the output register.
// A stalled rsp_tready freezes the sequencer with the result held.
// Reset clears the fill count and sequencer; stored bytes are not cleared.
`include "terminal_line_editor_echo_top_macros.svh"

module terminal_line_editor_echo_top #(
   parameter int LINE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data, [13:8] line_length, [15:14] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);

   localparam logic [tle_pkg::LEN_W-1:0] MAX_LEN = tle_pkg::LEN_W'(LINE_DEPTH);

   tle_pkg::cmd_type  cmd;
   tle_pkg::stat_type stat;
   logic              take_beat;
   logic              end_beat;

   assign take_beat = req_tvalid && req_tready;
   assign end_beat  = rsp_tvalid && (rsp_tuser == tle_pkg::KIND_END);

   // sequencer
   tle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // line store, counters, item build and output register
   tle_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // one byte at a time: a taken byte always occupies the decode cycle
   `TLE_ASSERT_NXT(a_busy_after_take, clock, reset, take_beat, !req_tready, "ready after take")
   // a line-end beat closes its byte's results
   `TLE_ASSERT_IMP(a_end_is_last, clock, reset, end_beat, rsp_tlast, "line end without tlast")
   // reported length never exceeds the store depth
   `TLE_ASSERT_IMP(a_len_bound, clock, reset, end_beat, rsp_tdata[13:8] <= MAX_LEN, "len over depth")

endmodule

/* src/tle_ctrl.sv */
module tle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tle_pkg::stat_type stat,
   output tle_pkg::cmd_type  cmd
);

   tle_pkg::state_type state_ff;
   tle_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.mode     = tle_pkg::MODE_ECHO;
      unique case (state_ff)
         tle_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = tle_pkg::ST_DECODE;
            end
         end
         tle_pkg::ST_DECODE: begin
            priority if (stat.is_bs) begin
               if (stat.empty) begin
                  state_in = tle_pkg::ST_IDLE;
               end else begin
                  cmd.pop      = 1'b1;
                  cmd.step_clr = 1'b1;
                  state_in     = tle_pkg::ST_ERASE;
               end
            end else if (stat.is_cr) begin
               cmd.step_clr = 1'b1;
               state_in     = tle_pkg::ST_LINE;
            end else if (stat.full) begin
               // no room: byte is dropped without echo
               state_in = tle_pkg::ST_IDLE;
            end else begin
               cmd.store    = 1'b1;
               cmd.step_clr = 1'b1;
               state_in     = tle_pkg::ST_ECHO;
            end
         end
         tle_pkg::ST_ECHO, tle_pkg::ST_ERASE, tle_pkg::ST_LINE: begin
            if (state_ff == tle_pkg::ST_ERASE) begin
               cmd.mode = tle_pkg::MODE_ERASE;
            end else if (state_ff == tle_pkg::ST_LINE) begin
               cmd.mode = tle_pkg::MODE_LINE;
            end
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.final_step) begin
                  cmd.clear = (state_ff == tle_pkg::ST_LINE);
                  state_in  = tle_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = tle_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* src/tle_dp.sv */
module tle_dp #(
   parameter int LINE_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tle_pkg::BYTE_W-1:0]    req_tdata,
   input  tle_pkg::cmd_type              cmd,
   output tle_pkg::stat_type             stat,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,
   output logic [tle_pkg::KIND_W-1:0]    rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int FILL_W = $clog2(LINE_DEPTH + 1);
   localparam int IDX_W  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int STEP_W = tle_pkg::STEP_W;

   logic [tle_pkg::BYTE_W-1:0] byte_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;
   logic [STEP_W-1:0]          step_ff;
   logic [STEP_W-1:0]          step_in;
   logic [tle_pkg::BYTE_W-1:0] rd_ff;
   logic [tle_pkg::BYTE_W-1:0] mem [LINE_DEPTH];

   logic                       out_valid_ff;
   logic [tle_pkg::KIND_W-1:0] out_kind_ff;
   logic [tle_pkg::BYTE_W-1:0] out_data_ff;
   logic [tle_pkg::LEN_W-1:0]  out_len_ff;
   logic                       out_last_ff;

   logic [tle_pkg::KIND_W-1:0] kind_c;
   logic [tle_pkg::BYTE_W-1:0] data_c;
   logic [tle_pkg::LEN_W-1:0]  len_c;
   logic [STEP_W-1:0]          final_c;
   logic [STEP_W-1:0]          group_c;
   logic [STEP_W-1:0]          line_end;
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;
   tle_pkg::byte_class_type    cur_cls;
   tle_pkg::byte_class_type    gone_cls;

   assign cur_cls  = tle_pkg::byte_class(byte_ff);
   assign gone_cls = tle_pkg::byte_class(rd_ff);
   assign line_end = STEP_W'(fill_ff) + STEP_W'(2);

   // item for the current step
   always_comb begin
      kind_c  = tle_pkg::KIND_ECHO;
      data_c  = byte_ff;
      len_c   = '0;
      final_c = '0;
      group_c = STEP_W'(1);
      unique case (cmd.mode)
         tle_pkg::MODE_ECHO: begin
            unique case (cur_cls)
               tle_pkg::CLS_CTRL: begin
                  final_c = STEP_W'(1);
                  data_c  = (step_ff == '0) ? tle_pkg::CH_CARET
                                            : byte_ff + tle_pkg::CTRL_OFS;
               end
               tle_pkg::CLS_HIGH: begin
                  final_c = STEP_W'(3);
                  unique case (step_ff[1:0])
                     2'd0:    data_c = tle_pkg::CH_BSLASH;
                     2'd1:    data_c = tle_pkg::CH_X;
                     2'd2:    data_c = tle_pkg::hex_digit(byte_ff[7:4]);
                     default: data_c = tle_pkg::hex_digit(byte_ff[3:0]);
                  endcase
               end
               default: begin
                  final_c = '0;
               end
            endcase
         end
         tle_pkg::MODE_ERASE: begin
            // BS run, SP run, BS run; run length follows the removed byte's echo
            unique case (gone_cls)
               tle_pkg::CLS_CTRL: begin
                  group_c = STEP_W'(2);
                  final_c = STEP_W'(5);
               end
               tle_pkg::CLS_HIGH: begin
                  group_c = STEP_W'(4);
                  final_c = STEP_W'(11);
               end
               default: begin
                  group_c = STEP_W'(1);
                  final_c = STEP_W'(2);
               end
            endcase
            data_c = (step_ff < group_c || step_ff >= (group_c << 1)) ? tle_pkg::CH_BS
                                                                     : tle_pkg::CH_SP;
         end
         tle_pkg::MODE_LINE: begin
            final_c = line_end;
            priority if (step_ff == STEP_W'(0)) begin
               data_c = tle_pkg::CH_CR;
            end else if (step_ff == STEP_W'(1)) begin
               data_c = tle_pkg::CH_LF;
            end else if (step_ff < line_end) begin
               kind_c = tle_pkg::KIND_LINE;
               data_c = rd_ff;
            end else begin
               kind_c = tle_pkg::KIND_END;
               data_c = '0;
               len_c  = tle_pkg::LEN_W'(fill_ff);
            end
         end
         default: begin
            final_c = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.step_clr) begin
         step_in = '0;
      end else if (cmd.emit) begin
         step_in = step_ff + STEP_W'(1);
      end else begin
         step_in = step_ff;
      end

      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.store) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (cmd.pop) begin
         fill_in = fill_ff - FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end

      // read address tracks the next step so rd_ff lines up with step_ff
      rd_en   = cmd.pop || (cmd.mode == tle_pkg::MODE_LINE &&
                            step_in >= STEP_W'(2) && step_in < line_end);
      rd_addr = cmd.pop ? IDX_W'(fill_ff - FILL_W'(1)) : IDX_W'(step_in - STEP_W'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (cmd.load) begin
         byte_ff <= req_tdata;
      end
      if (cmd.emit) begin
         out_kind_ff <= kind_c;
         out_data_ff <= data_c;
         out_len_ff  <= len_c;
         out_last_ff <= (step_ff == final_c);
      end
   end

   // line store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[IDX_W'(fill_ff)] <= byte_ff;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign stat.is_bs      = (byte_ff == tle_pkg::CH_BS) || (byte_ff == tle_pkg::CH_DEL);
   assign stat.is_cr      = (byte_ff == tle_pkg::CH_CR);
   assign stat.empty      = (fill_ff == '0);
   assign stat.full       = (fill_ff == FILL_W'(LINE_DEPTH));
   assign stat.final_step = (step_ff == final_c);
   assign stat.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_len_ff, out_data_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* tb/tb_terminal_line_editor_echo_top.sv */
// Line editor bench: a behavioral model of the line buffer predicts every
// result beat; a monitor compares each rsp beat with the oldest prediction.
module tb_terminal_line_editor_echo_top;
   import tle_pkg::*;

   localparam int LINE_DEPTH = 32;
   localparam int RANDOM_ITEMS = 350;

   // one predicted result beat
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              lst;
   } tty_beat_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] data, [13:8] line_length
   logic [1:0]  rsp_tuser;           // [1:0] kind
   logic        rsp_tlast;

   // shadow of the editor state
   logic [BYTE_W-1:0] line_buf [LINE_DEPTH];
   int                line_fill = 0;

   tty_beat_type tty_out_q [$];   // beats still owed by the block
   int           mismatch_cnt = 0;
   bit           idle_on = 1'b1;  // 0: both sides run flat out

   terminal_line_editor_echo_top #(
      .LINE_DEPTH(LINE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog. Worst case is roughly 410 bytes, each a full-line CR of
   // 35 beats with the longest random stall before every beat plus the
   // longest send gap. Allow several times that.
   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------
   function automatic void push_beat(input logic [KIND_W-1:0] kind,
                                     input logic [BYTE_W-1:0] data,
                                     input int len);
      tty_beat_type b;
      b.kind = kind;
      b.data = data;
      b.len  = len[LEN_W-1:0];
      b.lst  = 1'b0;
      tty_out_q.push_back(b);
   endfunction

   // rubout: n BS, n SP, n BS
   function automatic void push_rubout(input int n);
      for (int i = 0; i < 3 * n; i++) begin
         push_beat(KIND_ECHO, (i / n == 1) ? CH_SP : CH_BS, 0);
      end
   endfunction

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
      logic [BYTE_W-1:0] c;
      c = (nib < 4'd10) ? 8'd48 + nib : 8'd55 + nib;   // '0'.. / 'A'..
      return c;
   endfunction

   // Apply one received byte to the shadow line; queue its beats.
   // Returns how many beats it owes.
   function automatic int tty_predict(input logic [BYTE_W-1:0] rx);
      int        n_before;
      logic [BYTE_W-1:0] gone;
      tty_beat_type tail;
      n_before = tty_out_q.size();
      if (rx == CH_BS || rx == CH_DEL) begin
         if (line_fill > 0) begin
            line_fill--;
            gone = line_buf[line_fill];
            if (gone < CH_SP) begin
               push_rubout(2);
            end else if (gone > CH_DEL) begin
               push_rubout(4);
            end else begin
               push_rubout(1);
            end
         end
      end else if (rx == CH_CR) begin
         push_beat(KIND_ECHO, CH_CR, 0);
         push_beat(KIND_ECHO, CH_LF, 0);
         for (int i = 0; i < line_fill; i++) begin
            push_beat(KIND_LINE, line_buf[i], 0);
         end
         push_beat(KIND_END, 8'd0, line_fill);
         line_fill = 0;
      end else if (line_fill < LINE_DEPTH) begin
         if (rx < CH_SP) begin
            push_beat(KIND_ECHO, CH_CARET, 0);
            push_beat(KIND_ECHO, rx + CTRL_OFS, 0);
         end else if (rx > CH_DEL) begin
            push_beat(KIND_ECHO, CH_BSLASH, 0);
            push_beat(KIND_ECHO, CH_X, 0);
            push_beat(KIND_ECHO, hex_char(rx[7:4]), 0);
            push_beat(KIND_ECHO, hex_char(rx[3:0]), 0);
         end else begin
            push_beat(KIND_ECHO, rx, 0);
         end
         line_buf[line_fill] = rx;
         line_fill++;
      end
      // full line: byte is dropped, nothing owed
      if (tty_out_q.size() > n_before) begin
         tail = tty_out_q.pop_back();
         tail.lst = 1'b1;
         tty_out_q.push_back(tail);
      end
      return tty_out_q.size() - n_before;
   endfunction

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------
   // One rx beat: random gap, then hold valid until accepted.
   // A zero gap keeps tvalid high straight into the next byte.
   task automatic send_rx_byte(input logic [7:0] rx, output int n_beats);
      int gap;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= rx;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      n_beats = tty_predict(rx);
   endtask

   task automatic send_byte(input logic [7:0] rx);
      int n;
      send_rx_byte(rx, n);
   endtask

   // any byte that lands in the line buffer
   function automatic logic [7:0] storable_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_BS || b == CH_DEL || b == CH_CR);
      return b;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tty_out_q.size() != 0) @(posedge clock);
   endtask

   // Result side back-pressure: random stall before each beat.
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      tty_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tty_out_q.size() == 0) begin
            $error("unexpected beat: kind %0d data %02h len %0d last %0b",
                   rsp_tuser, rsp_tdata[7:0], rsp_tdata[13:8], rsp_tlast);
            mismatch_cnt++;
         end else begin
            want = tty_out_q.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               mismatch_cnt++;
            end
            if (rsp_tdata[7:0] !== want.data) begin
               $error("data: expected %02h, got %02h", want.data, rsp_tdata[7:0]);
               mismatch_cnt++;
            end
            if (rsp_tdata[13:8] !== want.len) begin
               $error("line_length: expected %0d, got %0d", want.len, rsp_tdata[13:8]);
               mismatch_cnt++;
            end
            if (rsp_tlast !== want.lst) begin
               $error("last: expected %0b, got %0b", want.lst, rsp_tlast);
               mismatch_cnt++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Rubout on an empty line owes nothing; CR on an empty line gives
   // CR LF and a zero-length end beat.
   task automatic test_empty_line();
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(CH_CR);
   endtask

   // One byte of each echo class and the field extremes, then rubouts of
   // each class, then flush the rest of the line.
   task automatic test_echo_classes();
      send_byte(8'd0);      // ^@
      send_byte(8'd31);     // top control
      send_byte(8'd10);     // LF is just a control byte here
      send_byte(8'd32);     // space, lowest plain
      send_byte(8'd126);    // highest plain
      send_byte(8'd128);    // lowest high byte
      send_byte(8'd255);
      send_byte(8'h9A);     // mixed hex digits
      send_byte(8'd27);     // ESC
      send_byte(8'h41);     // 'A'
      send_byte(CH_DEL);    // rub out plain
      send_byte(CH_BS);     // rub out control
      send_byte(CH_DEL);    // rub out high
      send_byte(CH_CR);
   endtask

   // Fill the line, push extra bytes into a full buffer, rub one out and
   // refill, then CR: the longest burst the block can emit.
   task automatic test_full_line();
      wait_drained();       // let the block go fully idle first
      idle_on = 1'b0;
      for (int i = 0; i < LINE_DEPTH; i++) send_byte(storable_byte());
      idle_on = 1'b1;
      repeat (3) send_byte(storable_byte());   // dropped
      send_byte(CH_BS);
      send_byte(storable_byte());
      send_byte(storable_byte());              // dropped again
      send_byte(CH_CR);
   endtask

   // Mostly well-formed lines with random content and a few rubouts;
   // some lines run past full, some never see their CR, plus raw noise.
   task automatic test_random_lines();
      int counted;
      int len;
      logic [7:0] rx;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            // raw noise
            repeat ($urandom_range(1, 6)) begin
               send_byte(8'($urandom_range(0, 255)));
               counted++;
            end
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                              : $urandom_range(0, 12);
            for (int i = 0; i < len; i++) begin
               rx = ($urandom_range(0, 11) == 0)
                  ? (($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL)
                  : storable_byte();
               send_byte(rx);
               counted++;
            end
            if ($urandom_range(0, 7) != 0) begin
               send_byte(CH_CR);
               counted++;
            end
         end
      end
      send_byte(CH_CR);     // flush whatever is left
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_line();
      test_echo_classes();
      test_full_line();
      test_random_lines();

      wait_drained();
      // give stray beats time to show up
      repeat (64) @(posedge clock);
      if (tty_out_q.size() != 0) begin
         $error("%0d result beats never arrived", tty_out_q.size());
         mismatch_cnt++;
      end
      if (mismatch_cnt == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/tle_pkg.sv
src/tle_ctrl.sv
src/tle_dp.sv
src/terminal_line_editor_echo_top.sv
tb/tb_terminal_line_editor_echo_top.sv
